@@ rtl/core/s5hs_pkg.sv @@
package s5hs_pkg;

    typedef enum logic [3:0] {
        PH_GREET_VER,
        PH_GREET_NMETH,
        PH_METHODS,
        PH_REQ_VER,
        PH_REQ_CMD,
        PH_REQ_RSV,
        PH_REQ_ATYP,
        PH_IPV4,
        PH_DOM_LEN,
        PH_DOM_NAME,
        PH_IPV6,
        PH_PORT_HI,
        PH_PORT_LO,
        PH_IDLE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_REPLY,
        KIND_NAME,
        KIND_PARSED,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        JOB_METHOD,
        JOB_NAME,
        JOB_REQUEST,
        JOB_ERROR
    } t_job_op;

    localparam logic [2:0] ERR_GREET_VER = 3'd0;
    localparam logic [2:0] ERR_REQ_VER   = 3'd1;
    localparam logic [2:0] ERR_COMMAND   = 3'd2;
    localparam logic [2:0] ERR_RESERVED  = 3'd3;
    localparam logic [2:0] ERR_ATYP      = 3'd4;

    localparam logic [7:0] SOCKS_VERSION = 8'h05;
    localparam logic [7:0] CMD_CONNECT   = 8'h01;
    localparam logic [7:0] CMD_UDP_ASSOC = 8'h03;
    localparam logic [7:0] ATYP_IPV4     = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [7:0] ATYP_IPV6     = 8'h04;
    localparam logic [7:0] REP_SUCCESS   = 8'h00;
    localparam logic [7:0] RSV_BYTE      = 8'h00;
    localparam logic [7:0] METHOD_NOAUTH = 8'h00;

    localparam logic [1:0] AT_IPV4   = 2'd0;
    localparam logic [1:0] AT_DOMAIN = 2'd1;
    localparam logic [1:0] AT_IPV6   = 2'd2;

    localparam logic [7:0] IPV4_LEN = 8'd4;
    localparam logic [7:0] IPV6_LEN = 8'd16;

    // Result positions within a job.
    localparam logic [3:0] IDX_METHOD_LAST  = 4'd1;
    localparam logic [3:0] IDX_REQUEST_LAST = 4'd10;

    localparam logic CFG_BOUND_ADDRESS = 1'b0;
    localparam logic CFG_BOUND_PORT    = 1'b1;

    localparam logic [31:0] BOUND_ADDRESS_RESET = 32'h7F00_0001;
    localparam logic [15:0] BOUND_PORT_RESET    = 16'h0000;

    typedef struct packed {
        t_job_op     op;
        logic [7:0]  data;
        logic [2:0]  err;
        logic [1:0]  command;
        logic [1:0]  atype;
        logic [31:0] ipv4;
        logic [15:0] port;
        logic [7:0]  dlen;
    } t_job;

    typedef struct packed {
        t_kind       kind;
        logic        last;
        logic [7:0]  data;
        logic [1:0]  command;
        logic [1:0]  atype;
        logic [31:0] ipv4;
        logic [15:0] port;
        logic [7:0]  dlen;
        logic [2:0]  err;
    } t_result;

endpackage

@@ rtl/core/s5hs_front.sv @@
module s5hs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  logic           i_new_session,
    input  logic           i_full,
    output logic           o_ready,
    output logic           o_push,
    output s5hs_pkg::t_job o_job
);

    s5hs_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [1:0]  r_command, n_command;
    logic [1:0]  r_atype, n_atype;
    logic [31:0] r_addr, n_addr;
    logic [7:0]  r_port_hi, n_port_hi;
    logic [7:0]  r_name_len, n_name_len;

    s5hs_pkg::t_phase ph;
    logic [7:0]  dec;
    logic        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s5hs_pkg::PH_GREET_VER;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte_count <= n_byte_count;
        r_command    <= n_command;
        r_atype      <= n_atype;
        r_addr       <= n_addr;
        r_port_hi    <= n_port_hi;
        r_name_len   <= n_name_len;
    end

    // Only the phase needs clearing on a new session: every other field is
    // written on the way to the place where it is read.
    always_comb begin
        ph           = i_new_session ? s5hs_pkg::PH_GREET_VER : r_phase;
        dec          = r_byte_count - 8'd1;
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_command    = r_command;
        n_atype      = r_atype;
        n_addr       = r_addr;
        n_port_hi    = r_port_hi;
        n_name_len   = r_name_len;
        o_push       = 1'b0;
        o_job        = '0;
        if (accept) begin
            n_phase = ph;
            unique case (ph)
                s5hs_pkg::PH_GREET_VER: begin
                    if (i_byte != s5hs_pkg::SOCKS_VERSION) begin
                        o_push    = 1'b1;
                        o_job.op  = s5hs_pkg::JOB_ERROR;
                        o_job.err = s5hs_pkg::ERR_GREET_VER;
                        n_phase   = s5hs_pkg::PH_IDLE;
                    end else begin
                        n_phase = s5hs_pkg::PH_GREET_NMETH;
                    end
                end
                s5hs_pkg::PH_GREET_NMETH, s5hs_pkg::PH_METHODS: begin
                    n_byte_count = (ph == s5hs_pkg::PH_GREET_NMETH) ? i_byte : dec;
                    if (n_byte_count == 8'd0) begin
                        o_push   = 1'b1;
                        o_job.op = s5hs_pkg::JOB_METHOD;
                        n_phase  = s5hs_pkg::PH_REQ_VER;
                    end else begin
                        n_phase = s5hs_pkg::PH_METHODS;
                    end
                end
                s5hs_pkg::PH_REQ_VER: begin
                    if (i_byte != s5hs_pkg::SOCKS_VERSION) begin
                        o_push    = 1'b1;
                        o_job.op  = s5hs_pkg::JOB_ERROR;
                        o_job.err = s5hs_pkg::ERR_REQ_VER;
                        n_phase   = s5hs_pkg::PH_IDLE;
                    end else begin
                        n_phase = s5hs_pkg::PH_REQ_CMD;
                    end
                end
                s5hs_pkg::PH_REQ_CMD: begin
                    if (i_byte >= s5hs_pkg::CMD_CONNECT && i_byte <= s5hs_pkg::CMD_UDP_ASSOC)
                    begin
                        n_command = 2'(i_byte - s5hs_pkg::CMD_CONNECT);
                        n_phase   = s5hs_pkg::PH_REQ_RSV;
                    end else begin
                        o_push    = 1'b1;
                        o_job.op  = s5hs_pkg::JOB_ERROR;
                        o_job.err = s5hs_pkg::ERR_COMMAND;
                        n_phase   = s5hs_pkg::PH_IDLE;
                    end
                end
                s5hs_pkg::PH_REQ_RSV: begin
                    if (i_byte != s5hs_pkg::RSV_BYTE) begin
                        o_push    = 1'b1;
                        o_job.op  = s5hs_pkg::JOB_ERROR;
                        o_job.err = s5hs_pkg::ERR_RESERVED;
                        n_phase   = s5hs_pkg::PH_IDLE;
                    end else begin
                        n_phase = s5hs_pkg::PH_REQ_ATYP;
                    end
                end
                s5hs_pkg::PH_REQ_ATYP: begin
                    priority if (i_byte == s5hs_pkg::ATYP_IPV4) begin
                        n_atype      = s5hs_pkg::AT_IPV4;
                        n_addr       = '0;
                        n_byte_count = s5hs_pkg::IPV4_LEN;
                        n_phase      = s5hs_pkg::PH_IPV4;
                    end else if (i_byte == s5hs_pkg::ATYP_DOMAIN) begin
                        n_atype = s5hs_pkg::AT_DOMAIN;
                        n_phase = s5hs_pkg::PH_DOM_LEN;
                    end else if (i_byte == s5hs_pkg::ATYP_IPV6) begin
                        n_atype      = s5hs_pkg::AT_IPV6;
                        n_byte_count = s5hs_pkg::IPV6_LEN;
                        n_phase      = s5hs_pkg::PH_IPV6;
                    end else begin
                        o_push    = 1'b1;
                        o_job.op  = s5hs_pkg::JOB_ERROR;
                        o_job.err = s5hs_pkg::ERR_ATYP;
                        n_phase   = s5hs_pkg::PH_IDLE;
                    end
                end
                s5hs_pkg::PH_IPV4: begin
                    n_addr       = {r_addr[23:0], i_byte};
                    n_byte_count = dec;
                    if (dec == 8'd0) begin
                        n_phase = s5hs_pkg::PH_PORT_HI;
                    end
                end
                s5hs_pkg::PH_DOM_LEN: begin
                    n_name_len   = i_byte;
                    n_byte_count = i_byte;
                    n_phase = (i_byte == 8'd0) ? s5hs_pkg::PH_PORT_HI
                                               : s5hs_pkg::PH_DOM_NAME;
                end
                s5hs_pkg::PH_DOM_NAME: begin
                    o_push       = 1'b1;
                    o_job.op     = s5hs_pkg::JOB_NAME;
                    o_job.data   = i_byte;
                    n_byte_count = dec;
                    if (dec == 8'd0) begin
                        n_phase = s5hs_pkg::PH_PORT_HI;
                    end
                end
                s5hs_pkg::PH_IPV6: begin
                    n_byte_count = dec;
                    if (dec == 8'd0) begin
                        n_phase = s5hs_pkg::PH_PORT_HI;
                    end
                end
                s5hs_pkg::PH_PORT_HI: begin
                    n_port_hi = i_byte;
                    n_phase   = s5hs_pkg::PH_PORT_LO;
                end
                s5hs_pkg::PH_PORT_LO: begin
                    o_push        = 1'b1;
                    o_job.op      = s5hs_pkg::JOB_REQUEST;
                    o_job.command = r_command;
                    o_job.atype   = r_atype;
                    o_job.ipv4    = (r_atype == s5hs_pkg::AT_IPV4) ? r_addr : 32'd0;
                    o_job.port    = {r_port_hi, i_byte};
                    o_job.dlen    = (r_atype == s5hs_pkg::AT_DOMAIN) ? r_name_len : 8'd0;
                    n_phase       = s5hs_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = s5hs_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/s5hs_queue.sv @@
module s5hs_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  s5hs_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output s5hs_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    s5hs_pkg::t_job r_entry [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ rtl/core/s5hs_back.sv @@
module s5hs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  s5hs_pkg::t_job    i_job,
    output logic              o_pop,
    input  logic [31:0]       i_bound_address,
    input  logic [15:0]       i_bound_port,
    input  logic              i_ready,
    output logic              o_valid,
    output s5hs_pkg::t_result o_result
);

    logic [3:0]        r_idx;
    logic              r_valid;
    s5hs_pkg::t_result r_result;
    s5hs_pkg::t_result res;
    logic              fire;

    assign fire     = i_job_valid && (!r_valid || i_ready);
    assign o_pop    = fire && res.last;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        res = '0;
        unique case (i_job.op)
            s5hs_pkg::JOB_METHOD: begin
                res.kind = s5hs_pkg::KIND_REPLY;
                res.last = (r_idx == s5hs_pkg::IDX_METHOD_LAST);
                res.data = res.last ? s5hs_pkg::METHOD_NOAUTH : s5hs_pkg::SOCKS_VERSION;
            end
            s5hs_pkg::JOB_NAME: begin
                res.kind = s5hs_pkg::KIND_NAME;
                res.last = 1'b1;
                res.data = i_job.data;
            end
            s5hs_pkg::JOB_ERROR: begin
                res.kind = s5hs_pkg::KIND_ERROR;
                res.last = 1'b1;
                res.err  = i_job.err;
            end
            s5hs_pkg::JOB_REQUEST: begin
                // First the parsed request, then the ten reply bytes.
                res.last = (r_idx == s5hs_pkg::IDX_REQUEST_LAST);
                if (r_idx == 4'd0) begin
                    res.kind    = s5hs_pkg::KIND_PARSED;
                    res.command = i_job.command;
                    res.atype   = i_job.atype;
                    res.ipv4    = i_job.ipv4;
                    res.port    = i_job.port;
                    res.dlen    = i_job.dlen;
                end else begin
                    res.kind = s5hs_pkg::KIND_REPLY;
                    unique case (r_idx)
                        4'd1:    res.data = s5hs_pkg::SOCKS_VERSION;
                        4'd2:    res.data = s5hs_pkg::REP_SUCCESS;
                        4'd3:    res.data = s5hs_pkg::RSV_BYTE;
                        4'd4:    res.data = s5hs_pkg::ATYP_IPV4;
                        4'd5:    res.data = i_bound_address[31:24];
                        4'd6:    res.data = i_bound_address[23:16];
                        4'd7:    res.data = i_bound_address[15:8];
                        4'd8:    res.data = i_bound_address[7:0];
                        4'd9:    res.data = i_bound_port[15:8];
                        4'd10:   res.data = i_bound_port[7:0];
                        default: res.data = 8'd0;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_idx <= res.last ? 4'd0 : r_idx + 4'd1;
            end
            if (fire) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= res;
        end
    end

endmodule

@@ rtl/core/socks5_handshake_parser.sv @@
// A byte that ends a job is queued; its result words are registered at the output.
// Throughput: one input byte per cycle while the job queue has room; one result word
// per cycle while m_axis_tready is high, so a completed request gives eleven result
// words. The queue between parser and emitter lets bytes arrive throughout that burst.
// Reset (synchronous, active low) returns to the greeting, empties the queue and
// restores the bound address to 127.0.0.1 and the bound port to zero.
module socks5_handshake_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] new_session
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [9:8] command, [11:10] address_type, [43:12] ipv4_address,
    // [59:44] destination_port, [67:60] domain_length, [70:68] error_code, [71] zero
    output logic [71:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // last
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_bound_address;
    logic [15:0] r_bound_port;

    logic              push, full, pop, job_valid;
    s5hs_pkg::t_job    job_in, job_out;
    s5hs_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_address <= s5hs_pkg::BOUND_ADDRESS_RESET;
            r_bound_port    <= s5hs_pkg::BOUND_PORT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                s5hs_pkg::CFG_BOUND_ADDRESS: r_bound_address <= i_cfg_data;
                s5hs_pkg::CFG_BOUND_PORT:    r_bound_port    <= i_cfg_data[15:0];
            endcase
        end
    end

    s5hs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata),
        .i_new_session (s_axis_tuser),
        .i_full        (full),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_job         (job_in)
    );

    s5hs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    s5hs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job_out),
        .o_pop           (pop),
        .i_bound_address (r_bound_address),
        .i_bound_port    (r_bound_port),
        .i_ready         (m_axis_tready),
        .o_valid         (m_axis_tvalid),
        .o_result        (result)
    );

    assign m_axis_tdata = {1'b0, result.err, result.dlen, result.port, result.ipv4,
                           result.atype, result.command, result.data};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule
